[src/ed3_pkg.sv]
// shared types and widths for the 3-d euclidean distance engine
package ed3_pkg;

    localparam int COORD_W  = 24;
    localparam int DIMS     = 3;
    localparam int DIFF_W   = COORD_W + 1;
    localparam int MAG_W    = COORD_W;
    localparam int SQ_W     = 2 * MAG_W;
    localparam int SUM_W    = SQ_W + 2;
    localparam int ROOT_W   = SUM_W / 2;
    localparam int REM_W    = ROOT_W + 2;
    localparam int LANE_LAT = 2;
    localparam int DIST_MAX = 29058990;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [DIMS-1:0][COORD_W-1:0] coord_vec_t;
    typedef logic [SQ_W-1:0] sq_t;
    typedef logic [DIMS-1:0][SQ_W-1:0] sq_vec_t;
    typedef logic [SUM_W-1:0] sum_t;
    typedef logic [ROOT_W-1:0] root_t;

    typedef struct packed {
        logic valid;
        logic last;
    } ctl_t;

    typedef struct packed {
        coord_t a_x;
        coord_t a_y;
        coord_t a_z;
        coord_t b_x;
        coord_t b_y;
        coord_t b_z;
        logic   last_pair;
    } pair_t;

    typedef struct packed {
        root_t distance;
        logic  last;
    } result_t;

endpackage

[src/ed3_lane.sv]
// one coordinate lane: difference, magnitude and square
module ed3_lane (
    input  logic           clk,
    input  logic           en,
    input  ed3_pkg::coord_t a,
    input  ed3_pkg::coord_t b,
    output ed3_pkg::sq_t    sq
);
    import ed3_pkg::*;

    logic signed [DIFF_W-1:0] diff;
    logic [DIFF_W-1:0]        mag_full;
    logic [MAG_W-1:0]         mag_reg;
    logic [MAG_W-1:0]         mag_next;
    sq_t                      sq_reg;
    sq_t                      sq_next;

    assign diff     = {a[COORD_W-1], a} - {b[COORD_W-1], b};
    assign mag_full = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
    // magnitude stays below 2^24, so the top bit is always clear
    assign mag_next = mag_full[MAG_W-1:0];
    assign sq_next  = mag_reg * mag_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg <= mag_next;
            sq_reg  <= sq_next;
        end
    end

    assign sq = sq_reg;

endmodule

[src/ed3_merge.sv]
// merging stage: adds the squares of the three lanes at full width
module ed3_merge (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  ed3_pkg::sq_vec_t sq,
    input  ed3_pkg::ctl_t    ctl_in,
    output ed3_pkg::sum_t    sum,
    output ed3_pkg::ctl_t    ctl_out
);
    import ed3_pkg::*;

    sum_t sum_reg;
    sum_t sum_next;
    ctl_t ctl_reg;

    always_comb
    begin
        sum_next = '0;
        for (int k = 0; k < DIMS; k++)
        begin
            sum_next = sum_next + SUM_W'(sq[k]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_reg <= sum_next;
        end
    end

    assign sum     = sum_reg;
    assign ctl_out = ctl_reg;

endmodule

[src/ed3_sqrt.sv]
// pipelined integer square root, one root bit per stage
module ed3_sqrt (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  ed3_pkg::sum_t  sum,
    input  ed3_pkg::ctl_t  ctl_in,
    output ed3_pkg::root_t root,
    output ed3_pkg::ctl_t  ctl_out
);
    import ed3_pkg::*;

    sum_t             rad_reg [ROOT_W];
    logic [REM_W-1:0] rem_reg [ROOT_W];
    root_t            q_reg   [ROOT_W];
    ctl_t             ctl_reg [ROOT_W];

    for (genvar s = 0; s < ROOT_W; s++)
    begin : g_stage
        sum_t             rad_in;
        logic [REM_W-1:0] rem_in;
        root_t            q_in;
        ctl_t             ctl_stage;
        logic [REM_W-1:0] shifted;
        logic [REM_W-1:0] trial;
        logic [REM_W-1:0] rem_diff;
        logic [REM_W-1:0] rem_next;
        root_t            q_next;
        logic             ge;

        if (s == 0)
        begin : g_first
            assign rad_in    = sum;
            assign rem_in    = '0;
            assign q_in      = '0;
            assign ctl_stage = ctl_in;
        end
        else
        begin : g_rest
            assign rad_in    = rad_reg[s-1];
            assign rem_in    = rem_reg[s-1];
            assign q_in      = q_reg[s-1];
            assign ctl_stage = ctl_reg[s-1];
        end

        // remainder never exceeds twice the partial root, so its top two bits are clear
        assign shifted  = {rem_in[REM_W-3:0], rad_in[SUM_W-1-2*s -: 2]};
        assign trial    = {q_in, 2'b01};
        assign ge       = (shifted >= trial);
        assign rem_diff = shifted - trial;
        assign rem_next = ge ? rem_diff : shifted;
        assign q_next   = {q_in[ROOT_W-2:0], ge};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctl_reg[s] <= '0;
            end
            else if (en)
            begin
                ctl_reg[s] <= ctl_stage;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rad_reg[s] <= rad_in;
                rem_reg[s] <= rem_next;
                q_reg[s]   <= q_next;
            end
        end
    end

    assign root    = q_reg[ROOT_W-1];
    assign ctl_out = ctl_reg[ROOT_W-1];

endmodule

[src/euclidean_distance_3d.sv]
// top level of the pairwise 3-d euclidean distance engine
// Takes one point pair per cycle while pair_stall is low and returns
// floor(sqrt(dx^2+dy^2+dz^2)) in unsigned Q25.0, one result per pair, in order,
// with last copied from last_pair. A pair passes the two coordinate lane
// registers (difference, then square), the merging adder, the root pipeline
// (one root bit per stage) and the output register.
// The whole pipeline advances together; it holds only while a result sits in
// the output register with result_stall high, and pair_stall follows that.
module euclidean_distance_3d (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             pair_valid,
    output logic             pair_stall,
    input  ed3_pkg::pair_t   pair_data,
    output logic             result_valid,
    input  logic             result_stall,
    output ed3_pkg::result_t result_data
);
    import ed3_pkg::*;

    logic       en;
    coord_vec_t a_vec;
    coord_vec_t b_vec;
    sq_vec_t    sq_vec;
    ctl_t       in_ctl;
    ctl_t       lane_ctl_reg [LANE_LAT];
    ctl_t       sum_ctl;
    ctl_t       root_ctl;
    sum_t       sum;
    root_t      root;
    logic       result_valid_reg;
    logic       result_valid_next;
    result_t    result_reg;
    result_t    result_next;

    // everything moves unless a finished transaction is held at the output
    assign en         = !(result_valid_reg && result_stall);
    assign pair_stall = !en;

    assign a_vec  = {pair_data.a_z, pair_data.a_y, pair_data.a_x};
    assign b_vec  = {pair_data.b_z, pair_data.b_y, pair_data.b_x};
    assign in_ctl = '{valid: pair_valid, last: pair_data.last_pair};

    for (genvar k = 0; k < DIMS; k++)
    begin : g_lane
        ed3_lane u_lane (
            .clk (clk),
            .en  (en),
            .a   (a_vec[k]),
            .b   (b_vec[k]),
            .sq  (sq_vec[k])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LANE_LAT; i++)
            begin
                lane_ctl_reg[i] <= '0;
            end
        end
        else if (en)
        begin
            lane_ctl_reg[0] <= in_ctl;
            for (int i = 1; i < LANE_LAT; i++)
            begin
                lane_ctl_reg[i] <= lane_ctl_reg[i-1];
            end
        end
    end

    ed3_merge u_merge (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .sq      (sq_vec),
        .ctl_in  (lane_ctl_reg[LANE_LAT-1]),
        .sum     (sum),
        .ctl_out (sum_ctl)
    );

    ed3_sqrt u_sqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .sum     (sum),
        .ctl_in  (sum_ctl),
        .root    (root),
        .ctl_out (root_ctl)
    );

    assign result_valid_next = root_ctl.valid;
    assign result_next       = '{distance: root, last: root_ctl.last};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result_data  = result_reg;

    // an accepted pair enters the lane control chain
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (pair_valid && !pair_stall) |=> lane_ctl_reg[0].valid)
        else $error("accepted pair did not enter the lanes");

    // a held output freezes the merging stage
    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> $stable(sum_ctl) && $stable(sum))
        else $error("pipeline moved while the output was held");

    // no distance exceeds DIST_MAX, which lies just above the diagonal of the coordinate cube
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result_data.distance <= ROOT_W'(DIST_MAX)))
        else $error("distance out of range");

endmodule
